@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg - text console writer shared types
// Beat types for the command and response channels, the classified item that
// passes from front to back, status flags and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] COLOR_RESET = 8'h0F;
  localparam logic [7:0] BLANK_ATTR  = 8'h00;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } tcw_rsp_t;

  typedef enum logic [2:0] {
    K_WRITE,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_BACKSPACE,
    K_CLEAR,
    K_READ,
    K_NOP
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        in_range;
  } tcw_item_t;

  typedef struct packed {
    logic busy;
    logic take;
    logic read_wait;
  } tcw_status_t;

endpackage

@@ sv/text_console_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_top - character-cell text console
// Screen store of ROWS x COLUMNS cells with cursor, control characters,
// scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          beat
//   cmd      in   cmd_valid/stall    operation, char_code, cell_index
//   rsp      out  rsp_valid/stall    cell_value, cursor_row, cursor_column
//   cfg      in   cfg_valid/ready    text_color
//
// Put, nop and out-of-range read execute straight from idle in the back end;
// in-range read adds a registered store read. Scroll refills one row of
// COLUMNS cells, clear sweeps all ROWS*COLUMNS cells; the single store
// write port serves both. After reset a sweep of all ROWS*COLUMNS cells
// (2000 by default) runs before any item executes; cfg stays open throughout.
// The two-entry queue keeps cmd open, until full, while rsp_stall holds the back end.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tcw_pkg::tcw_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tcw_pkg::tcw_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import tcw_pkg::*;

  logic        q_full;
  logic        q_push;
  tcw_item_t   push_item;
  logic        q_pop;
  logic        q_valid;
  tcw_item_t   q_item;
  tcw_status_t status;

  assign cfg_ready = 1'b1;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_stall(cmd_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .rsp_stall(rsp_stall),
    .status   (status)
  );

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !status.take)
    else $error("item taken while back end busy");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(status.take) || $past(status.read_wait)))
    else $error("response raised without an executed item");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    status.read_wait |=> rsp_valid)
    else $error("read result not presented");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (((COLUMNS > 128) || (32'(rsp.cursor_column) < COLUMNS)) &&
                   ((ROWS > 32) || (32'(rsp.cursor_row) < ROWS))))
    else $error("cursor off screen");
`endif

endmodule

@@ sv/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front - command decode
// Accepts command beats, sorts each into a put, clear, read or nop kind,
// checks the read index against the screen size and pushes the item into the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               cmd_valid,
  input  tcw_pkg::tcw_cmd_t  cmd,
  output logic               cmd_stall,
  input  logic               q_full,
  output logic               q_push,
  output tcw_pkg::tcw_item_t q_item
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  tcw_kind_t kind;

  always_comb begin
    case (cmd.operation)
      OP_PUT: begin
        case (cmd.char_code)
          CH_NEWLINE:   kind = K_NEWLINE;
          CH_RETURN:    kind = K_RETURN;
          CH_TAB:       kind = K_TAB;
          CH_BACKSPACE: kind = K_BACKSPACE;
          default:      kind = K_WRITE;
        endcase
      end
      OP_CLEAR: kind = K_CLEAR;
      OP_READ:  kind = K_READ;
      default:  kind = K_NOP;
    endcase
  end

  assign q_item.kind       = kind;
  assign q_item.char_code  = cmd.char_code;
  assign q_item.cell_index = cmd.cell_index;
  assign q_item.in_range   = (32'(cmd.cell_index) < 32'(CELLS));

  assign cmd_stall = q_full;
  assign q_push    = cmd_valid && !q_full;

endmodule

@@ sv/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue - two-entry item queue
// Decouples decode from execution so that each side stalls on its own.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcw_pkg::tcw_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output tcw_pkg::tcw_item_t q_item
);
  import tcw_pkg::*;

  tcw_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back - cursor, screen store and result register
// Executes queued items. Rows live in the store as a ring: a scroll moves the
// top-row base and refills one row; clear sweeps the whole store.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  tcw_pkg::tcw_item_t   q_item,
  output logic                 q_pop,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  output logic                 rsp_valid,
  output tcw_pkg::tcw_rsp_t    rsp,
  input  logic                 rsp_stall,
  output tcw_pkg::tcw_status_t status
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AX    = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int CX    = CW + 1;
  localparam int RW    = $clog2(ROWS);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FILL  = 4'b0100,
    S_READ  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [RW-1:0] row, row_next;
  logic [CW-1:0] col, col_next;
  logic [AW-1:0] cur_base, cur_base_next;
  logic [AW-1:0] top_base, top_base_next;
  logic [AW-1:0] sweep_addr, sweep_addr_next;
  logic [AW-1:0] sweep_last, sweep_last_next;
  logic [7:0]    text_color;
  logic [7:0]    fill_color, fill_color_next;
  logic [15:0]   rd_data;
  logic [15:0]   mem [CELLS];
  logic          rsp_valid_next;
  tcw_rsp_t      rsp_next;
  logic          rsp_load;

  logic          take;
  logic          is_put;
  logic [CX-1:0] col_ext;
  logic [CX-1:0] ncol;
  logic          adv;
  logic          wrap;
  logic          scroll;
  logic [RW-1:0] put_row;
  logic [CW-1:0] put_col;
  logic [AX-1:0] top_sum;
  logic [AX-1:0] wsum;
  logic [AX-1:0] rsum;
  logic [AW-1:0] waddr_put;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  assign take  = q_valid && (state == S_IDLE) && (!rsp_valid || !rsp_stall);
  assign q_pop = take;

  assign is_put = (q_item.kind == K_WRITE) || (q_item.kind == K_NEWLINE) ||
                  (q_item.kind == K_RETURN) || (q_item.kind == K_TAB) ||
                  (q_item.kind == K_BACKSPACE);

  // cursor move for one put
  assign col_ext = {1'b0, col};

  always_comb begin
    adv  = 1'b0;
    ncol = col_ext;
    case (q_item.kind)
      K_NEWLINE: begin
        adv  = 1'b1;
        ncol = '0;
      end
      K_RETURN:    ncol = '0;
      K_TAB:       ncol = (col_ext + CX'(4)) & ~(CX'(3));
      K_BACKSPACE: ncol = (col == '0) ? col_ext : col_ext - CX'(1);
      K_WRITE:     ncol = col_ext + CX'(1);
      default:     ncol = col_ext;
    endcase
  end

  assign wrap    = (ncol >= CX'(COLUMNS));
  assign put_col = wrap ? '0 : ncol[CW-1:0];
  assign scroll  = (adv || wrap) && (row == RW'(ROWS - 1));
  assign put_row = ((adv || wrap) && !scroll) ? row + RW'(1) : row;

  assign top_sum = {1'b0, top_base} + AX'(COLUMNS);

  // physical address: logical index rotated by the top-row base
  assign wsum      = {1'b0, cur_base} + AX'(col) + {1'b0, top_base};
  assign waddr_put = (wsum >= AX'(CELLS)) ? AW'(wsum - AX'(CELLS)) : wsum[AW-1:0];
  assign rsum      = AX'(q_item.cell_index) + {1'b0, top_base};
  assign raddr     = (rsum >= AX'(CELLS)) ? AW'(rsum - AX'(CELLS)) : rsum[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = waddr_put;
    wdata = {text_color, q_item.char_code};
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = {BLANK_ATTR, CH_SPACE};
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = sweep_addr;
        wdata = {fill_color, CH_SPACE};
      end
      S_IDLE:  we = take && (q_item.kind == K_WRITE);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    cur_base_next   = cur_base;
    top_base_next   = top_base;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    fill_color_next = fill_color;
    rsp_load        = 1'b0;
    rsp_next        = rsp;
    case (state)
      S_CLEAR, S_FILL: begin
        sweep_addr_next = sweep_addr + AW'(1);
        if (sweep_addr == sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        rsp_load   = 1'b1;
        rsp_next   = '{cell_value: rd_data, cursor_row: 5'(row), cursor_column: 7'(col)};
      end
      S_IDLE: begin
        if (take) begin
          rsp_load = 1'b1;
          rsp_next = '{cell_value: 16'd0, cursor_row: 5'(row), cursor_column: 7'(col)};
          if (is_put) begin
            row_next = put_row;
            col_next = put_col;
            rsp_next.cursor_row    = 5'(put_row);
            rsp_next.cursor_column = 7'(put_col);
            if ((adv || wrap) && !scroll) begin
              cur_base_next = cur_base + AW'(COLUMNS);
            end
            if (scroll) begin
              state_next      = S_FILL;
              sweep_addr_next = top_base;
              sweep_last_next = top_base + AW'(COLUMNS - 1);
              fill_color_next = text_color;
              top_base_next   = (top_sum >= AX'(CELLS)) ? AW'(top_sum - AX'(CELLS))
                                                        : top_sum[AW-1:0];
            end
          end else if (q_item.kind == K_CLEAR) begin
            state_next      = S_CLEAR;
            sweep_addr_next = '0;
            sweep_last_next = AW'(CELLS - 1);
            row_next        = '0;
            col_next        = '0;
            cur_base_next   = '0;
            top_base_next   = '0;
            rsp_next.cursor_row    = 5'd0;
            rsp_next.cursor_column = 7'd0;
          end else if ((q_item.kind == K_READ) && q_item.in_range) begin
            state_next = S_READ;
            rsp_load   = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      row        <= '0;
      col        <= '0;
      cur_base   <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_last <= AW'(CELLS - 1);
      text_color <= COLOR_RESET;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      row        <= row_next;
      col        <= col_next;
      cur_base   <= cur_base_next;
      top_base   <= top_base_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fill_color <= fill_color_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  assign status.busy      = (state != S_IDLE);
  assign status.take      = take;
  assign status.read_wait = (state == S_READ);

endmodule
